/* sv/trq_pkg.sv */
// shared constants, types and counter helpers for the task run queue
`timescale 1ns / 1ps
`default_nettype none

package trq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_RUN     = 32;
  localparam int TASK_W      = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int RUN_W       = $clog2(MAX_RUN + 1);

  typedef enum logic [1:0] {
    MODE_PUT  = 2'd0,
    MODE_GET  = 2'd1,
    MODE_GRAB = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic put;
    logic emit_next;
    logic inherit;
    logic emit_empty;
    logic rd_issue;
    logic emit_rd;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic             next_valid;
    logic             ring_empty;
    logic             ring_full;
    logic [RUN_W-1:0] run_len;
    logic             out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] cnt_to_addr(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] a;
    a = (c >= CNT_W'(QUEUE_DEPTH)) ? c - CNT_W'(QUEUE_DEPTH) : c;
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    n = (c == CNT_W'(2 * QUEUE_DEPTH - 1)) ? '0 : c + 1'b1;
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] occupancy(input logic [CNT_W-1:0] t,
                                                 input logic [CNT_W-1:0] h);
    logic [CNT_W:0] d;
    d = {1'b0, t} + (CNT_W + 1)'(2 * QUEUE_DEPTH) - {1'b0, h};
    if (d >= (CNT_W + 1)'(2 * QUEUE_DEPTH)) begin
      d = d - (CNT_W + 1)'(2 * QUEUE_DEPTH);
    end
    return d[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/trq_ctrl.sv */
// controller state machine: decodes items and sequences ring reads
`timescale 1ns / 1ps
`default_nettype none

module trq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic          take_next_slot_i,
  input  wire trq_pkg::stat_t stat_i,
  output trq_pkg::cmd_t      cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_e;

  state_e                       state_q, state_d;
  logic [trq_pkg::RUN_W-1:0]    cnt_q, cnt_d;
  logic                         accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            trq_pkg::MODE_PUT: begin
              cmd_o.put = 1'b1;
            end
            trq_pkg::MODE_GET: begin
              if (stat_i.next_valid) begin
                cmd_o.emit_next = 1'b1;
                cmd_o.inherit   = 1'b1;
              end else if (stat_i.ring_empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.rd_issue = 1'b1;
                cnt_d          = '0;
                state_d        = S_DRAIN;
              end
            end
            trq_pkg::MODE_GRAB: begin
              if (!stat_i.ring_empty) begin
                cmd_o.rd_issue = 1'b1;
                cnt_d          = stat_i.run_len - 1'b1;
                state_d        = S_DRAIN;
              end else if (take_next_slot_i && stat_i.next_valid) begin
                cmd_o.emit_next = 1'b1;
              end else begin
                cmd_o.emit_empty = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          cmd_o.last    = (cnt_q == '0);
          if (cnt_q != '0) begin
            cmd_o.rd_issue = 1'b1;
            cnt_d          = cnt_q - 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* sv/trq_dp.sv */
// datapath: ring memory, head and tail counters, next slot, output register
`timescale 1ns / 1ps
`default_nettype none

module trq_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [trq_pkg::TASK_W-1:0]  task_id_i,
  input  wire logic                        to_next_slot_i,
  input  wire trq_pkg::cmd_t               cmd_i,
  output trq_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [trq_pkg::TASK_W-1:0]       out_task_o,
  output logic [1:0]                       status_o,
  output logic                             inherit_time_o,
  output logic                             last_o
);

  logic [trq_pkg::TASK_W-1:0] mem [trq_pkg::QUEUE_DEPTH];
  logic [trq_pkg::TASK_W-1:0] rdata_q;

  logic [trq_pkg::CNT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [trq_pkg::TASK_W-1:0] next_task_q, next_task_d;
  logic                       next_valid_q, next_valid_d;

  logic                       out_valid_q, out_valid_d;
  logic [trq_pkg::TASK_W-1:0] out_task_q, out_task_d;
  trq_pkg::status_e           status_q, status_d;
  logic                       inherit_q, inherit_d;
  logic                       last_q, last_d;

  logic [trq_pkg::CNT_W-1:0]  occ;
  logic [trq_pkg::CNT_W:0]    half_up;
  logic                       full;
  logic                       need_push;
  logic                       do_write;
  logic [trq_pkg::TASK_W-1:0] bound;
  logic                       load;

  assign occ     = trq_pkg::occupancy(tail_q, head_q);
  assign half_up = ({1'b0, occ} + 1'b1) >> 1;
  assign full    = (occ >= trq_pkg::CNT_W'(trq_pkg::QUEUE_DEPTH));

  assign need_push = !to_next_slot_i || next_valid_q;
  assign bound     = to_next_slot_i ? next_task_q : task_id_i;
  assign do_write  = cmd_i.put && need_push && !full;

  assign load = cmd_i.put || cmd_i.emit_next || cmd_i.emit_empty || cmd_i.emit_rd;

  always_comb begin
    stat_o.next_valid = next_valid_q;
    stat_o.ring_empty = (occ == '0);
    stat_o.ring_full  = full;
    stat_o.out_free   = !out_valid_q || out_ready_i;
    if (32'(half_up) > 32'(trq_pkg::MAX_RUN)) begin
      stat_o.run_len = trq_pkg::RUN_W'(trq_pkg::MAX_RUN);
    end else begin
      stat_o.run_len = trq_pkg::RUN_W'(half_up);
    end
  end

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    next_task_d  = next_task_q;
    next_valid_d = next_valid_q;
    out_task_d   = out_task_q;
    status_d     = status_q;
    inherit_d    = inherit_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (do_write) begin
      tail_d = trq_pkg::cnt_inc(tail_q);
    end
    if (cmd_i.rd_issue) begin
      head_d = trq_pkg::cnt_inc(head_q);
    end

    if (load) begin
      out_valid_d = 1'b1;
      out_task_d  = '0;
      status_d    = trq_pkg::ST_OK;
      inherit_d   = 1'b0;
      last_d      = 1'b1;
    end

    if (cmd_i.put) begin
      if (need_push && full) begin
        status_d = trq_pkg::ST_FULL;
      end
      if (to_next_slot_i) begin
        next_task_d  = task_id_i;
        next_valid_d = 1'b1;
      end
    end

    if (cmd_i.emit_next) begin
      out_task_d   = next_task_q;
      inherit_d    = cmd_i.inherit;
      next_task_d  = '0;
      next_valid_d = 1'b0;
    end

    if (cmd_i.emit_empty) begin
      status_d = trq_pkg::ST_EMPTY;
    end

    if (cmd_i.emit_rd) begin
      out_task_d = rdata_q;
      last_d     = cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[trq_pkg::cnt_to_addr(tail_q)] <= bound;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[trq_pkg::cnt_to_addr(head_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      next_task_q  <= '0;
      next_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      next_task_q  <= next_task_d;
      next_valid_q <= next_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_task_q <= out_task_d;
    status_q   <= status_d;
    inherit_q  <= inherit_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_task_o     = out_task_q;
  assign status_o       = status_q;
  assign inherit_time_o = inherit_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

/* sv/task_run_queue_with_next_slot_top.sv */
// top level of the task run queue: ring plus next slot, put, get and grab
// put, get from the next slot and empty results: the result is registered in the cycle after the item is taken
// get from the ring: the memory read is registered in rdata_q, then loaded into the output register
// grab of n tasks: a registered read first, then one result per cycle while the output is not stalled
// the next item is taken once the last result of the previous one is loaded
// reset empties the ring and the next slot at once; ring contents are undefined
`timescale 1ns / 1ps
`default_nettype none

module task_run_queue_with_next_slot_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] task_id_i,
  input  wire logic        to_next_slot_i,
  input  wire logic        take_next_slot_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      out_task_o,
  output logic [1:0]       status_o,
  output logic             inherit_time_o,
  output logic             last_o
);

  trq_pkg::cmd_t  cmd;
  trq_pkg::stat_t stat;

  trq_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .take_next_slot_i (take_next_slot_i),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  trq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .task_id_i      (task_id_i),
    .to_next_slot_i (to_next_slot_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_task_o     (out_task_o),
    .status_o       (status_o),
    .inherit_time_o (inherit_time_o),
    .last_o         (last_o)
  );

  a_get_next_inherits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == trq_pkg::MODE_GET) && stat.next_valid
    |=> out_valid_o && inherit_time_o && last_o)
    else $error("get from next slot did not return an inherit result");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("item accepted in the middle of a grab run");

  a_read_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |-> !stat.ring_empty)
    else $error("ring read while ring is empty");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.ring_full |-> !stat.ring_empty && !cmd.emit_empty)
    else $error("ring full and empty at once");

endmodule

`default_nettype wire
